[rtl/dlr48_pkg.sv]
// shared constants, command and status types for the downmix resampler
package dlr48_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_W     = 16;
  localparam int COUNT_W      = 4;
  localparam int RATE_W       = 18;
  localparam int PHASE_W      = 19;
  localparam int OUTPUT_RATE  = 48000;
  localparam int MIN_STEP     = 8000;

  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_INPUT_RATE    = 1'b1;

  typedef struct packed {
    logic load_frame;
    logic sum;
    logic mono_mul;
    logic mono_set;
    logic int_mul;
    logic int_div;
    logic emit_int;
    logic emit_hold;
    logic emit_mark;
    logic store;
    logic commit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic have;
    logic last;
    logic p_below;
    logic fits;
    logic any_out;
    logic out_free;
  } status_t;

endpackage

[rtl/dlr48_ctrl.sv]
// sequencing state machine for downmix, interpolation, hold and end marker
module dlr48_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  dlr48_pkg::status_t status,
  output dlr48_pkg::cmd_t    cmd
);
  import dlr48_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SUM    = 10'b00_0000_0010,
    ST_MMUL   = 10'b00_0000_0100,
    ST_MONO   = 10'b00_0000_1000,
    ST_DECIDE = 10'b00_0001_0000,
    ST_IMUL   = 10'b00_0010_0000,
    ST_IDIV   = 10'b00_0100_0000,
    ST_IEMIT  = 10'b00_1000_0000,
    ST_HOLD   = 10'b01_0000_0000,
    ST_MARK   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_frame = 1'b1;
          state_next     = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MMUL;
      end
      ST_MMUL: begin
        cmd.mono_mul = 1'b1;
        state_next   = ST_MONO;
      end
      ST_MONO: begin
        cmd.mono_set = 1'b1;
        state_next   = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.have && !status.last) begin
          cmd.store  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.have && status.p_below && (!status.last || status.fits)) begin
          state_next = ST_IMUL;
        end else if (!status.last) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else if (status.fits) begin
          state_next = ST_HOLD;
        end else if (!status.any_out) begin
          state_next = ST_MARK;
        end else begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_IMUL: begin
        cmd.int_mul = 1'b1;
        state_next  = ST_IDIV;
      end
      ST_IDIV: begin
        cmd.int_div = 1'b1;
        state_next  = ST_IEMIT;
      end
      ST_IEMIT: begin
        if (status.out_free) begin
          cmd.emit_int = 1'b1;
          state_next   = ST_DECIDE;
        end
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.emit_hold = 1'b1;
          state_next    = ST_DECIDE;
        end
      end
      ST_MARK: begin
        if (status.out_free) begin
          cmd.emit_mark = 1'b1;
          state_next    = ST_DECIDE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/dlr48_dpath.sv]
// datapath: config registers, channel average, phase stepping, interpolation, output register
module dlr48_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [17:0]         cfg_data,
  input  logic [127:0]        frame_data,
  input  logic                frame_last,
  input  dlr48_pkg::cmd_t     cmd,
  output dlr48_pkg::status_t  status,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);
  import dlr48_pkg::*;

  // output rate split into a power of two and an odd factor
  localparam int ODD_SHIFT   = 7;
  localparam int OUT_ODD     = OUTPUT_RATE >> ODD_SHIFT;
  localparam int RECIP_SHIFT = 33;
  localparam logic [24:0] OUT_RECIP =
    25'(((longint'(1) << RECIP_SHIFT) + longint'(OUT_ODD) - 1) / longint'(OUT_ODD));
  localparam int MONO_SHIFT  = 24;

  logic [COUNT_W-1:0]        chan_count;
  logic [RATE_W-1:0]         input_rate;
  logic signed [SAMPLE_W-1:0] chan [NUM_CHANNELS];
  logic                      last_q;
  logic signed [18:0]        sum;
  logic signed [18:0]        sum_next;
  logic [18:0]               quo_mono;
  logic                      mono_neg;
  logic signed [SAMPLE_W-1:0] mono;
  logic signed [SAMPLE_W-1:0] prev;
  logic                      have;
  logic [RATE_W-1:0]         phase;
  logic [PHASE_W-1:0]        p;
  logic                      any_out;
  logic signed [31:0]        num;
  logic [15:0]               quo_int;
  logic                      int_neg;

  logic [COUNT_W-1:0]        nch;
  logic [2:0]                nch_idx;
  logic [24:0]               mono_recip;
  logic [RATE_W-1:0]         rate_eff;
  logic [18:0]               sum_abs;
  logic [43:0]               mono_prod;
  logic [18:0]               mono_twos;
  logic signed [16:0]        diff;
  logic signed [16:0]        p_s;
  logic signed [33:0]        dprod;
  logic signed [33:0]        base;
  logic [30:0]               num_abs;
  logic [48:0]               int_prod;
  logic [15:0]               int_val;
  logic [19:0]               step1;
  logic [20:0]               step2;
  logic                      fits2;
  logic                      end_flag;

  always_comb begin
    if (chan_count == '0) begin
      nch = COUNT_W'(1);
    end else if (chan_count > COUNT_W'(NUM_CHANNELS)) begin
      nch = COUNT_W'(NUM_CHANNELS);
    end else begin
      nch = chan_count;
    end
  end

  assign nch_idx  = 3'(nch - COUNT_W'(1));
  assign rate_eff = (input_rate < RATE_W'(MIN_STEP)) ? RATE_W'(MIN_STEP) : input_rate;

  // rounded-up reciprocals of the channel count
  always_comb begin
    unique case (nch_idx)
      3'd0: mono_recip = 25'(2**24);
      3'd1: mono_recip = 25'((2**24 + 1) / 2);
      3'd2: mono_recip = 25'((2**24 + 2) / 3);
      3'd3: mono_recip = 25'((2**24 + 3) / 4);
      3'd4: mono_recip = 25'((2**24 + 4) / 5);
      3'd5: mono_recip = 25'((2**24 + 5) / 6);
      3'd6: mono_recip = 25'((2**24 + 6) / 7);
      3'd7: mono_recip = 25'((2**24 + 7) / 8);
    endcase
  end

  always_comb begin
    sum_next = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (c < int'(nch)) begin
        sum_next = sum_next + 19'(chan[c]);
      end
    end
  end

  assign sum_abs   = sum[18] ? 19'(-sum) : 19'(sum);
  assign mono_prod = 44'(sum_abs) * 44'(mono_recip);
  assign mono_twos = mono_neg ? (19'd0 - quo_mono) : quo_mono;

  assign diff     = 17'(mono) - 17'(prev);
  assign p_s      = signed'({1'b0, p[15:0]});
  assign dprod    = 34'(diff) * 34'(p_s);
  assign base     = 34'(prev) * 34'(OUTPUT_RATE);
  assign num_abs  = num[31] ? 31'(-num) : 31'(num);
  assign int_prod = 49'(num_abs[30:ODD_SHIFT]) * 49'(OUT_RECIP);
  assign int_val  = int_neg ? (16'd0 - quo_int) : quo_int;

  assign step1    = 20'(p) + 20'(rate_eff);
  assign step2    = 21'(step1) + 21'(rate_eff);
  assign fits2    = (step2 <= 21'(2 * OUTPUT_RATE));
  assign end_flag = last_q && !fits2;

  always_comb begin
    status.have     = have;
    status.last     = last_q;
    status.p_below  = (p < PHASE_W'(OUTPUT_RATE));
    status.fits     = (step1 <= 20'(2 * OUTPUT_RATE));
    status.any_out  = any_out;
    status.out_free = !m_tvalid || m_tready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= COUNT_W'(1);
      input_rate <= RATE_W'(24000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: chan_count <= cfg_data[COUNT_W-1:0];
        CFG_INPUT_RATE:    input_rate <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // frame capture and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan[c] <= frame_data[c*SAMPLE_W +: SAMPLE_W];
      end
      last_q <= frame_last;
    end
    if (cmd.sum) begin
      sum <= sum_next;
    end
    if (cmd.mono_mul) begin
      quo_mono <= mono_prod[42:MONO_SHIFT];
      mono_neg <= sum[18];
    end
    if (cmd.mono_set) begin
      mono <= mono_twos[15:0];
    end
    if (cmd.int_mul) begin
      num <= 32'(base + dprod);
    end
    if (cmd.int_div) begin
      quo_int <= int_prod[48:RECIP_SHIFT];
      int_neg <= num[31];
    end
  end

  // converter state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev    <= '0;
      have    <= 1'b0;
      phase   <= '0;
      any_out <= 1'b0;
      p       <= '0;
    end else begin
      if (cmd.mono_set) begin
        p       <= have ? PHASE_W'(phase) : PHASE_W'(OUTPUT_RATE);
        any_out <= 1'b0;
      end
      if (cmd.emit_int || cmd.emit_hold) begin
        p <= PHASE_W'(step1);
      end
      if (cmd.emit_int || cmd.emit_hold || cmd.emit_mark) begin
        any_out <= 1'b1;
      end
      if (cmd.store) begin
        prev  <= mono;
        have  <= 1'b1;
        phase <= '0;
      end
      if (cmd.commit) begin
        prev  <= mono;
        phase <= RATE_W'(p - PHASE_W'(OUTPUT_RATE));
      end
      if (cmd.clear) begin
        prev  <= '0;
        have  <= 1'b0;
        phase <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_int || cmd.emit_hold || cmd.emit_mark) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_int) begin
      m_tdata <= int_val;
      m_tuser <= 1'b1;
      m_tlast <= end_flag;
    end else if (cmd.emit_hold) begin
      m_tdata <= mono;
      m_tuser <= 1'b1;
      m_tlast <= end_flag;
    end else if (cmd.emit_mark) begin
      m_tdata <= '0;
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
    end
  end

  emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_int || cmd.emit_hold || cmd.emit_mark) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while a transaction is pending");

  interp_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.int_mul |-> (have && p < PHASE_W'(OUTPUT_RATE)))
    else $error("interpolation outside the phase window");

  hold_on_last_only: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_hold || cmd.emit_mark || cmd.clear) |-> last_q)
    else $error("end-of-clip handling on a frame that is not last");

  marker_ends_clip: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty result without end of clip");

endmodule

[rtl/downmix_linear_resampler_48k.sv]
// top level: mono downmix with linear resampling to 48 kHz
//
//   channel   | direction | payload
//   s_*       | in        | tdata: chan0_sample..chan7_sample (16 b each), tlast: last_frame
//   m_*       | out       | tdata: out_sample, tuser: has_sample, tlast: end_of_clip
//   cfg_*     | in        | index 0 channel_count, index 1 input_rate
//
// a frame passes through the load, sum, reciprocal multiply, mono set and decision steps
// each interpolated result then passes through product, reciprocal divide and emit steps
// each held repeat or end marker takes an emit step and a decision; one frame is in work at a time
// synchronous active-high reset; no clearing pass, the block is ready the cycle after
// a stalled output holds the state machine in its emit state until the pending transaction is taken
module downmix_linear_resampler_48k (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [17:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // chan0_sample .. chan7_sample
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // out_sample
  output logic         m_tuser,   // has_sample
  output logic         m_tlast
);
  import dlr48_pkg::*;

  cmd_t    cmd;
  status_t status;

  dlr48_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dlr48_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .frame_data (s_tdata),
    .frame_last (s_tlast),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[test/downmix_linear_resampler_48k_tb.sv]
// testbench for the downmix resampler: directed, rate-sweep and random traffic against a predictor
module downmix_linear_resampler_48k_tb;
  import dlr48_pkg::*;

  localparam int RESULT_CAP    = 13;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [15:0] sample;
    logic        has_sample;
    logic        end_of_clip;
  } mono_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_CHANNEL_COUNT;
  logic [17:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // chan0_sample .. chan7_sample
  logic         s_tlast = 1'b0; // last_frame
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;        // out_sample
  logic         m_tuser;        // has_sample
  logic         m_tlast;        // end_of_clip

  logic [3:0]   model_count = 4'd1;
  logic [17:0]  model_rate = 18'd24000;
  int           prev_mono = 0;
  bit           have_prev = 1'b0;
  logic [17:0]  phase_acc = '0;

  mono_result_t pending_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  downmix_linear_resampler_48k u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    mono_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected transaction, expected none, got sample %0d has %0b end %0b",
                 $time, $signed(m_tdata), m_tuser, m_tlast);
      end else begin
        want = pending_q.pop_front();
        if (want.sample !== m_tdata || want.has_sample !== m_tuser ||
            want.end_of_clip !== m_tlast) begin
          fail_count++;
          $display("%0t: mismatch, expected sample %0d has %0b end %0b, got %0d has %0b end %0b",
                   $time, $signed(want.sample), want.has_sample, want.end_of_clip,
                   $signed(m_tdata), m_tuser, m_tlast);
        end
      end
    end
  end

  task automatic queue_result(input logic [15:0] smp, input logic has, inout int n);
    mono_result_t r;
    if (n < RESULT_CAP) begin
      r.sample = smp;
      r.has_sample = has;
      r.end_of_clip = 1'b0;
      pending_q.push_back(r);
      n++;
    end
  endtask

  task automatic predict_frame(input logic [127:0] frame, input logic last);
    int nch;
    int acc;
    int mono;
    int n;
    longint step;
    longint p;
    longint v;
    mono_result_t tail;
    nch = model_count;
    if (nch < 1) nch = 1;
    if (nch > NUM_CHANNELS) nch = NUM_CHANNELS;
    step = model_rate;
    if (step < MIN_STEP) step = MIN_STEP;
    acc = 0;
    for (int c = 0; c < nch; c++) acc += $signed(frame[16*c +: 16]);
    mono = acc / nch;
    n = 0;
    if (!have_prev && !last) begin
      prev_mono = mono;
      have_prev = 1'b1;
      phase_acc = '0;
    end else begin
      if (!have_prev) begin
        // lone last frame: no interpolation, only held repeats or the end marker
        p = OUTPUT_RATE;
      end else begin
        p = phase_acc;
        while (p < OUTPUT_RATE && (!last || p + step <= 2 * OUTPUT_RATE)) begin
          v = (longint'(prev_mono) * (OUTPUT_RATE - p) + longint'(mono) * p) / OUTPUT_RATE;
          queue_result(v[15:0], 1'b1, n);
          p += step;
        end
      end
      if (!last) begin
        phase_acc = 18'(p - OUTPUT_RATE);
        prev_mono = mono;
      end else begin
        while (p + step <= 2 * OUTPUT_RATE) begin
          queue_result(mono[15:0], 1'b1, n);
          p += step;
        end
        if (n == 0) queue_result(16'd0, 1'b0, n);
        tail = pending_q.pop_back();
        tail.end_of_clip = 1'b1;
        pending_q.push_back(tail);
        prev_mono = 0;
        have_prev = 1'b0;
        phase_acc = '0;
      end
    end
  endtask

  task automatic send_frame(input logic [127:0] frame, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= frame;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_frame(frame, last);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] count, input logic [17:0] rate);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data <= {14'($urandom), count};
    @(posedge clk);
    model_count = count;
    cfg_index <= CFG_INPUT_RATE;
    cfg_data <= rate;
    @(posedge clk);
    model_rate = rate;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [127:0] random_frame();
    logic [127:0] f;
    int mode;
    mode = $urandom_range(0, 9);
    for (int c = 0; c < NUM_CHANNELS; c++) f[16*c +: 16] = 16'($urandom);
    if (mode == 0) f = {8{16'h7FFF}};
    else if (mode == 1) f = {8{16'h8000}};
    return f;
  endfunction

  function automatic logic [17:0] pick_rate();
    case ($urandom_range(0, 13))
      0: return 18'($urandom_range(0, 262143));
      1: return 18'($urandom_range(8000, 192000));
      2: return 18'd8000;
      3: return 18'd11025;
      4: return 18'd16000;
      5: return 18'd22050;
      6: return 18'd32000;
      7: return 18'd44100;
      8: return 18'd48000;
      9: return 18'd88200;
      10: return 18'd96000;
      11: return 18'd192000;
      12: return 18'($urandom_range(0, 7999));
      default: return 18'($urandom_range(192001, 262143));
    endcase
  endfunction

  task automatic run_clip(input int len);
    for (int i = 0; i < len; i++) send_frame(random_frame(), i == len - 1);
  endtask

  task automatic test_directed_edges();
    idle_pct = 0;
    stall_pct = 0;
    // one-frame and three-frame clips at reset settings
    send_frame({8{16'h7FFF}}, 1'b1);
    send_frame({8{16'h8000}}, 1'b0);
    send_frame({8{16'h7FFF}}, 1'b0);
    send_frame({8{16'h8000}}, 1'b1);
    // rate above 48k: a lone last frame gives only the end marker
    set_config(4'd8, 18'd96000);
    send_frame({8{16'h8000}}, 1'b1);
    send_frame({8{16'h7FFF}}, 1'b0);
    send_frame({4{16'h8000, 16'h7FFF}}, 1'b1);
    // zero count and zero rate fall back to one channel and the minimum step
    set_config(4'd0, 18'd0);
    send_frame({8{16'h8000}}, 1'b0);
    send_frame({8{16'h7FFF}}, 1'b0);
    send_frame({8{16'h0000}}, 1'b1);
    send_frame({8{16'hFFFF}}, 1'b1);
    // count saturates, rate beyond the nominal range
    set_config(4'd15, 18'h3FFFF);
    send_frame({8{16'h7FFF}}, 1'b0);
    send_frame({8{16'h8000}}, 1'b0);
    send_frame({8{16'h7FFF}}, 1'b1);
    set_config(4'd3, 18'd7999);
    send_frame({16'h1234, 16'h8001, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555,
                16'hAAAA}, 1'b0);
    send_frame({8{16'hFFFF}}, 1'b1);
  endtask

  task automatic test_rate_sweep();
    logic [3:0]  counts [6];
    logic [17:0] rates [6];
    counts = '{4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd5};
    rates  = '{18'd8000, 18'd11025, 18'd22050, 18'd44100, 18'd48000, 18'd192000};
    for (int i = 0; i < 6; i++) begin
      set_config(counts[i], rates[i]);
      run_clip(4);
    end
  endtask

  task automatic test_random_traffic();
    int idle_set [4];
    int stall_set [4];
    int sent;
    int len;
    bit paused;
    logic [3:0] count;
    idle_set  = '{0, 64, 0, 21};
    stall_set = '{0, 0, 64, 21};
    for (int ph = 0; ph < 4; ph++) begin
      if ($urandom_range(0, 3) == 0) count = 4'($urandom_range(0, 15));
      else count = 4'($urandom_range(1, 8));
      set_config(count, pick_rate());
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      sent = 0;
      paused = 1'b0;
      while (sent < 58) begin
        case ($urandom_range(0, 9))
          0: len = 1;
          1: len = $urandom_range(9, 14);
          default: len = $urandom_range(2, 8);
        endcase
        run_clip(len);
        sent += len;
        // hold the sender off until the output side has drained
        if (!paused && sent >= 29) begin
          wait_quiet();
          paused = 1'b1;
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_rate_sweep();
    test_random_traffic();
    wait_quiet();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
